[design/urlpd_pkg.sv]
// Package for the URL percent decoder.
// Holds character constants, the queue entry type and the hex helper functions.
// No dependencies.
package urlpd_pkg;

   // Characters that the decoder recognizes.
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UP_A    = 8'h41;
   localparam logic [7:0] CHAR_UP_F    = 8'h46;
   localparam logic [7:0] CHAR_LO_A    = 8'h61;
   localparam logic [7:0] CHAR_LO_F    = 8'h66;

   // One input byte causes at most this many output bytes.
   localparam int MAX_RESULTS = 3;

   typedef logic [1:0] res_count_type;

   // Work for the back end: the output bytes of one request transaction.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      res_count_type               count;
      logic                        has_data;
      logic                        str_end;
   } entry_type;

   // True for 0-9, A-F and a-f.
   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
             ((c >= CHAR_UP_A) && (c <= CHAR_UP_F)) ||
             ((c >= CHAR_LO_A) && (c <= CHAR_LO_F));
   endfunction

   // Lower-case hex letters become upper case; everything else is kept.
   function automatic logic [7:0] to_upper_hex(input logic [7:0] c);
      if ((c >= CHAR_LO_A) && (c <= CHAR_LO_F)) begin
         return c - CHAR_LO_A + CHAR_UP_A;
      end
      return c;
   endfunction

   // Value of one hex digit; zero for anything that is not a hex digit.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
         v = c - CHAR_ZERO;
      end else if ((c >= CHAR_UP_A) && (c <= CHAR_UP_F)) begin
         v = c - CHAR_UP_A + 8'd10;
      end else if ((c >= CHAR_LO_A) && (c <= CHAR_LO_F)) begin
         v = c - CHAR_LO_A + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

[design/urlpd_front.sv]
// Front end of the URL percent decoder: accepts request transactions,
// tracks the escape state and builds one queue entry per producing byte.
// Depends on urlpd_pkg.
module urlpd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_in_byte,
   input  logic               req_string_last,
   input  logic               queue_full,
   output logic               req_stall,
   output logic               push,
   output urlpd_pkg::entry_type push_entry
);
   import urlpd_pkg::*;

   logic       in_escape_ff, in_escape_in;
   logic       digits_held_ff, digits_held_in;
   logic [7:0] first_digit_ff, first_digit_in;
   logic       accept;
   logic       c_hex;
   entry_type  entry;

   // The queue is the only thing that holds the front end back.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign c_hex     = is_hex(req_in_byte);

   // Classify the byte and work out the escape state that follows it.
   always_comb begin
      in_escape_in   = in_escape_ff;
      digits_held_in = digits_held_ff;
      first_digit_in = first_digit_ff;
      entry          = '0;
      entry.has_data = 1'b1;

      if (in_escape_ff) begin
         if (!c_hex) begin
            // Broken escape: replay the percent sign, any held digit and the byte.
            entry.bytes[0] = CHAR_PERCENT;
            if (digits_held_ff) begin
               entry.bytes[1] = first_digit_ff;
               entry.bytes[2] = req_in_byte;
               entry.count    = 2'd3;
            end else begin
               entry.bytes[1] = req_in_byte;
               entry.count    = 2'd2;
            end
            in_escape_in   = 1'b0;
            digits_held_in = 1'b0;
            first_digit_in = 8'd0;
         end else if (!digits_held_ff) begin
            first_digit_in = to_upper_hex(req_in_byte);
            digits_held_in = 1'b1;
         end else begin
            entry.bytes[0] = {hex_value(first_digit_ff), hex_value(req_in_byte)};
            entry.count    = 2'd1;
            in_escape_in   = 1'b0;
            digits_held_in = 1'b0;
            first_digit_in = 8'd0;
         end
      end else if (req_in_byte == CHAR_PERCENT) begin
         in_escape_in   = 1'b1;
         digits_held_in = 1'b0;
         first_digit_in = 8'd0;
      end else if (req_in_byte == CHAR_PLUS) begin
         entry.bytes[0] = CHAR_SPACE;
         entry.count    = 2'd1;
      end else begin
         entry.bytes[0] = req_in_byte;
         entry.count    = 2'd1;
      end

      // The end of a string drops any open escape and always yields a result.
      if (req_string_last) begin
         in_escape_in   = 1'b0;
         digits_held_in = 1'b0;
         first_digit_in = 8'd0;
         entry.str_end  = 1'b1;
         if (entry.count == 2'd0) begin
            entry.bytes    = '0;
            entry.has_data = 1'b0;
            entry.count    = 2'd1;
         end
      end
   end

   assign push       = accept && (entry.count != 2'd0);
   assign push_entry = entry;

   // Escape state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_escape_ff   <= 1'b0;
         digits_held_ff <= 1'b0;
         first_digit_ff <= 8'd0;
      end else if (accept) begin
         in_escape_ff   <= in_escape_in;
         digits_held_ff <= digits_held_in;
         first_digit_ff <= first_digit_in;
      end
   end

endmodule

[design/urlpd_queue.sv]
// Short first-in first-out queue between the front and back ends.
// Head entry is visible without a read cycle. Depends on urlpd_pkg.
module urlpd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  urlpd_pkg::entry_type push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output urlpd_pkg::entry_type head_entry
);
   import urlpd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[design/urlpd_back.sv]
// Back end of the URL percent decoder: unpacks queue entries into
// response transactions, one byte per cycle while rsp_stall is low, through an output register.
// Depends on urlpd_pkg.
module urlpd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  urlpd_pkg::entry_type head_entry,
   output logic                 pop,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_run_last,
   output logic                 rsp_string_end
);
   import urlpd_pkg::*;

   res_count_type idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          byte_valid_ff, byte_valid_in;
   logic          run_last_ff, run_last_in;
   logic          string_end_ff, string_end_in;
   logic          load;
   logic          last_of_entry;
   logic [7:0]    sel_byte;

   // The output register takes a new value when it is empty or being taken.
   assign load          = !rsp_valid_ff || !rsp_stall;
   assign last_of_entry = (idx_ff == (head_entry.count - 2'd1));

   // Pick the byte of the head entry that goes out next.
   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head_entry.bytes[0];
         2'd1:    sel_byte = head_entry.bytes[1];
         default: sel_byte = head_entry.bytes[2];
      endcase
   end

   // Next output and position within the head entry.
   always_comb begin
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      run_last_in   = run_last_ff;
      string_end_in = string_end_ff;
      pop           = 1'b0;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            out_byte_in   = sel_byte;
            byte_valid_in = head_entry.has_data;
            run_last_in   = last_of_entry;
            string_end_in = last_of_entry && head_entry.str_end;
            if (last_of_entry) begin
               pop    = 1'b1;
               idx_in = 2'd0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the response transaction.
   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      run_last_ff   <= run_last_in;
      string_end_ff <= string_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_string_end = string_end_ff;

endmodule

[design/url_percent_decoder_top.sv]
// Top level of the streaming URL percent decoder.
// Instantiates urlpd_front, urlpd_queue and urlpd_back; depends on urlpd_pkg.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_in_byte, req_string_last
//   rsp_      out        rsp_valid/rsp_stall  rsp_out_byte, rsp_byte_valid,
//                                             rsp_run_last, rsp_string_end
//
// One request transaction is accepted per cycle while the queue has room.
// Each queued entry leaves as one to three response transactions, one per
// cycle while rsp_stall is low, so a broken escape gives the back end one or two
// extra transactions. A request reaches rsp_ through the queue and the output register.
// Reset clears the escape state, the queue and the valid bit of the output register.
// req_stall is high exactly when the queue (QUEUE_DEPTH entries) is full.
module url_percent_decoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_string_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);
   import urlpd_pkg::*;

   logic      push, pop, queue_full, head_valid;
   entry_type push_entry, head_entry;

   urlpd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_in_byte     (req_in_byte),
      .req_string_last (req_string_last),
      .queue_full      (queue_full),
      .req_stall       (req_stall),
      .push            (push),
      .push_entry      (push_entry)
   );

   urlpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   urlpd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule

[design/urlpd_checker.sv]
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends only on the ports of url_percent_decoder_top.
module urlpd_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_run_last,
   input logic       rsp_string_end
);

   // A stalled response transaction holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_byte_valid) && $stable(rsp_run_last) && $stable(rsp_string_end))
      else $error("stalled response changed");

   // An empty result only closes a string, and carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |->
         rsp_run_last && rsp_string_end && (rsp_out_byte == 8'd0))
      else $error("empty result outside string end");

   // The end of a string is also the last result of its input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_last)
      else $error("string end without run end");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind url_percent_decoder_top urlpd_port_checker u_urlpd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_run_last   (rsp_run_last),
   .rsp_string_end (rsp_string_end)
);

[tb/urlpd_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the URL percent decoder: watches the request and response
// channels, predicts the decoded stream and compares every response field.
// Depends on urlpd_pkg for the character constants.
module urlpd_checker
   import urlpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_string_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_byte_valid,
   input  logic       rsp_run_last,
   input  logic       rsp_string_end,
   output int         fail_count,
   output int         pending_count
);

   // One predicted response transaction.
   typedef struct packed {
      logic [7:0] data;
      logic       data_valid;
      logic       run_last;
      logic       string_end;
   } decoded_type;

   decoded_type decoded_q[$];

   // Predicted escape state.
   logic       esc_open;
   logic       digit_held;
   logic [7:0] held_digit;

   // Digits, upper-case A-F and lower-case a-f.
   function automatic logic hex_char(input logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) ||
             (c >= CHAR_UP_A && c <= CHAR_UP_F) ||
             (c >= CHAR_LO_A && c <= CHAR_LO_F);
   endfunction

   // Digits carry their value in the low nibble; letters sit nine above it.
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      return (c <= CHAR_NINE) ? c[3:0] : c[3:0] + 4'd9;
   endfunction

   // Clearing bit 5 upper-cases a letter.
   function automatic logic [7:0] upper_hex(input logic [7:0] c);
      return (c >= CHAR_LO_A && c <= CHAR_LO_F) ? (c & 8'hDF) : c;
   endfunction

   // Works out the responses one request transaction causes and queues them.
   task automatic decode_transaction(input logic [7:0] c, input logic last);
      logic [7:0]  emitted[3];
      int          n;
      decoded_type item;
      n = 0;
      if (esc_open) begin
         if (!hex_char(c)) begin
            // A broken escape gives back the percent sign, any held digit
            // and the offending byte itself.
            emitted[n] = CHAR_PERCENT;
            n = n + 1;
            if (digit_held) begin
               emitted[n] = held_digit;
               n = n + 1;
            end
            emitted[n] = c;
            n = n + 1;
            esc_open = 1'b0;
         end else if (!digit_held) begin
            held_digit = upper_hex(c);
            digit_held = 1'b1;
         end else begin
            emitted[n] = {nibble_of(held_digit), nibble_of(c)};
            n = n + 1;
            esc_open = 1'b0;
         end
         if (!esc_open) begin
            digit_held = 1'b0;
            held_digit = 8'd0;
         end
      end else if (c == CHAR_PERCENT) begin
         esc_open   = 1'b1;
         digit_held = 1'b0;
         held_digit = 8'd0;
      end else if (c == CHAR_PLUS) begin
         emitted[n] = CHAR_SPACE;
         n = n + 1;
      end else begin
         emitted[n] = c;
         n = n + 1;
      end

      // The end of a string drops any open escape.
      if (last) begin
         esc_open   = 1'b0;
         digit_held = 1'b0;
         held_digit = 8'd0;
      end

      for (int k = 0; k < n; k++) begin
         item.data       = emitted[k];
         item.data_valid = 1'b1;
         item.run_last   = (k == n - 1);
         item.string_end = last && (k == n - 1);
         decoded_q.push_back(item);
      end
      // A final byte with nothing decoded still ends the string.
      if (last && n == 0) begin
         item.data       = 8'd0;
         item.data_valid = 1'b0;
         item.run_last   = 1'b1;
         item.string_end = 1'b1;
         decoded_q.push_back(item);
      end
   endtask

   task automatic check_field(input string name, input int wanted, input int seen);
      if (wanted != seen) begin
         $display("%0t: %s expected %0h, actual %0h", $time, name, wanted, seen);
         fail_count++;
      end
   endtask

   // Predict on each accepted request, then check each accepted response.
   always @(posedge clock) begin
      decoded_type wanted;
      if (reset) begin
         esc_open      = 1'b0;
         digit_held    = 1'b0;
         held_digit    = 8'd0;
         fail_count    = 0;
         decoded_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            decode_transaction(req_in_byte, req_string_last);
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h/%b/%b/%b",
                        $time, rsp_out_byte, rsp_byte_valid, rsp_run_last,
                        rsp_string_end);
               fail_count++;
            end else begin
               wanted = decoded_q.pop_front();
               check_field("out_byte", int'(wanted.data), int'(rsp_out_byte));
               check_field("byte_valid", int'(wanted.data_valid), int'(rsp_byte_valid));
               check_field("run_last", int'(wanted.run_last), int'(rsp_run_last));
               check_field("string_end", int'(wanted.string_end), int'(rsp_string_end));
            end
         end
      end
      pending_count = decoded_q.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the URL percent decoder: clock, reset, request stimulus,
// response back-pressure and the final verdict. Depends on urlpd_pkg,
// url_percent_decoder_top and urlpd_checker.
module tb_top;
   import urlpd_pkg::*;

   localparam int RANDOM_ITEMS = 180;
   localparam int QUIET_AFTER  = 150;
   localparam int LIMIT_CYCLES = 200000;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte     = 8'd0;
   logic       req_string_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_run_last;
   logic       rsp_string_end;
   int         fail_count;
   int         pending_count;
   int         sent_count      = 0;
   logic       quiet           = 1'b0;

   url_percent_decoder_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_string_last (req_string_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_end  (rsp_string_end)
   );

   urlpd_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_string_last (req_string_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_end  (rsp_string_end),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // Response back-pressure: stall bursts mixed with free-running stretches.
   initial begin
      int pick;
      wait (!reset);
      forever begin
         @(negedge clock);
         pick = $urandom_range(0, 5);
         if (!quiet && pick == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (pick == 1) begin
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end
      end
   end

   // Sends one request transaction, with an occasional idle burst first.
   task automatic send_byte(input logic [7:0] c, input logic last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_in_byte     = c;
      req_string_last = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent_count++;
      quiet = (sent_count >= QUIET_AFTER);
   endtask

   function automatic logic [7:0] random_hex_digit();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'(CHAR_ZERO + r);
      if (r < 16) return 8'(CHAR_UP_A + r - 10);
      return 8'(CHAR_LO_A + r - 16);
   endfunction

   // Builds one string out of plain bytes, plus signs, good and broken escapes.
   task automatic send_string(input int pieces);
      logic [7:0] text[$];
      int         r;
      for (int p = 0; p < pieces; p++) begin
         r = $urandom_range(0, 19);
         if (r <= 6) begin
            text.push_back(8'($urandom_range(0, 255)));
         end else if (r <= 8) begin
            text.push_back(CHAR_PLUS);
         end else if (r <= 15) begin
            text.push_back(CHAR_PERCENT);
            text.push_back(random_hex_digit());
            text.push_back(random_hex_digit());
         end else if (r <= 17) begin
            text.push_back(CHAR_PERCENT);
            text.push_back(random_hex_digit());
            text.push_back(8'($urandom_range(0, 255)));
         end else if (r == 18) begin
            text.push_back(CHAR_PERCENT);
            text.push_back(8'($urandom_range(0, 255)));
         end else begin
            // Escape left open; it is dropped if the string ends here.
            text.push_back(CHAR_PERCENT);
            if ($urandom_range(0, 1)) text.push_back(random_hex_digit());
         end
      end
      foreach (text[i]) begin
         send_byte(text[i], i == text.size() - 1);
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed: byte extremes and plus sign.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_PLUS, 1'b0);
      // "%41" and "%fF" decode to one byte each.
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h31, 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(CHAR_LO_F, 1'b0);
      send_byte(CHAR_UP_F, 1'b0);
      // "%a%": the held digit comes back upper-cased and the percent is raw.
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(CHAR_LO_A, 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);
      // "%+": a plus sign inside an escape stays a plus sign.
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(CHAR_PLUS, 1'b0);
      // Unfinished escapes at the end of a string are dropped.
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(CHAR_ZERO, 1'b1);
      send_byte(CHAR_PERCENT, 1'b1);
      // A plus sign closing a string, then a broken escape closing one.
      send_byte(CHAR_PLUS, 1'b1);
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(CHAR_NINE, 1'b0);
      send_byte(8'h47, 1'b1);

      // Random strings until enough transactions have gone in.
      while (sent_count < RANDOM_ITEMS) begin
         send_string($urandom_range(1, 6));
      end
      req_valid       = 1'b0;
      req_string_last = 1'b0;

      // Drain, then allow the pipeline to settle.
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
design/urlpd_pkg.sv
design/urlpd_front.sv
design/urlpd_queue.sv
design/urlpd_back.sv
design/url_percent_decoder_top.sv
design/urlpd_checker.sv
tb/urlpd_checker.sv
tb/tb_top.sv
